/* sv/fwts_pkg.sv */
// Package for the friction wheel and trigger sequencer core.
// Holds register indexes, field widths, reset values and the saturating counter helper.
// No dependencies.
package fwts_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned ShortWidth = 8;
    localparam int unsigned LongWidth  = 10;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDataWidth = LongWidth;

    typedef logic [CountWidth-1:0] count_t;
    typedef logic [ShortWidth-1:0] short_t;
    typedef logic [LongWidth-1:0]  long_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
    typedef logic [CfgDataWidth-1:0] cfg_data_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_LONG_PRESS    = 2'd0,
        CFG_LOCKOUT       = 2'd1,
        CFG_SHOT_INTERVAL = 2'd2,
        CFG_PUSH          = 2'd3
    } cfg_reg_t;

    localparam short_t LONG_PRESS_RST    = 8'd40;
    localparam short_t LOCKOUT_RST       = 8'd200;
    localparam long_t  SHOT_INTERVAL_RST = 10'd100;
    localparam long_t  PUSH_RST          = 10'd20;
    localparam long_t  GAP_TIMER_RST     = 10'd200;
    localparam long_t  PUSH_TIMER_RST    = 10'd20;
    localparam logic signed [1:0] BURST_IDLE = -2'sd1;

    localparam count_t COUNT_MAX = '1;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        if (v == COUNT_MAX)
        begin
            r = COUNT_MAX;
        end
        else
        begin
            r = v + count_t'(1);
        end
        return r;
    endfunction

endpackage

/* sv/friction_wheel_and_trigger_sequencer_core.sv */
// Friction wheel on/off judge and firing cylinder sequencer, one control tick per transaction.
// Input register, single-pass update logic, and result register.
// Depends on fwts_pkg.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------------------------
//  in       | in_valid / in_ready       | active_mode, right_button, left_button,
//           |                           | switch_toggled
//  out      | out_valid / out_ready     | wheels_driven, cylinder_extended, shot_done,
//           |                           | feed_advance, switch_consumed
//  cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_ready is high; it passes through the input
// register and its result is written to the result register, where it waits until it is taken.
// The input register feeds the state update, which writes the result register in one pass.
// Reset sets the tick state to its reset values and loads the register defaults; no clearing pass.
// A stalled output holds the input register, and in_ready drops only when both stages are full.
module friction_wheel_and_trigger_sequencer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                active_mode,
    input  logic                right_button,
    input  logic                left_button,
    input  logic                switch_toggled,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                wheels_driven,
    output logic                cylinder_extended,
    output logic                shot_done,
    output logic                feed_advance,
    output logic                switch_consumed,
    input  logic                cfg_we,
    input  fwts_pkg::cfg_idx_t  cfg_index,
    input  fwts_pkg::cfg_data_t cfg_data
);
    import fwts_pkg::*;

    // Configuration registers
    short_t long_press_reg;
    short_t lockout_cfg_reg;
    long_t  shot_interval_reg;
    long_t  push_cfg_reg;

    // Input stage
    logic s1_valid_reg;
    logic s1_active_reg;
    logic s1_right_reg;
    logic s1_left_reg;
    logic s1_toggle_reg;
    logic s1_move;

    // Tick state
    logic              wheels_on_reg,   wheels_on_next;
    logic              wheel_drive_reg, wheel_drive_next;
    count_t            hold_count_reg,  hold_count_next;
    short_t            lockout_reg,     lockout_next;
    count_t            shots_reg,       shots_next;
    logic signed [1:0] burst_reg,       burst_next;
    logic              last_left_reg,   last_left_next;
    count_t            advances_reg,    advances_next;
    long_t             gap_reg,         gap_next;
    long_t             push_reg,        push_next;
    logic              cyl_reg,         cyl_next;
    logic              done_next;
    logic              feed_next;
    logic              consumed_next;

    // Result register
    logic out_valid_reg;
    logic out_drive_reg;
    logic out_cyl_reg;
    logic out_done_reg;
    logic out_feed_reg;
    logic out_consumed_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg    <= LONG_PRESS_RST;
            lockout_cfg_reg   <= LOCKOUT_RST;
            shot_interval_reg <= SHOT_INTERVAL_RST;
            push_cfg_reg      <= PUSH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LONG_PRESS:    long_press_reg    <= cfg_data[ShortWidth-1:0];
                CFG_LOCKOUT:       lockout_cfg_reg   <= cfg_data[ShortWidth-1:0];
                CFG_SHOT_INTERVAL: shot_interval_reg <= cfg_data;
                CFG_PUSH:          push_cfg_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_active_reg <= active_mode;
            s1_right_reg  <= right_button;
            s1_left_reg   <= left_button;
            s1_toggle_reg <= switch_toggled;
        end
    end

    // Wheel judge followed by the trigger sequencer, in the order the tick defines.
    always_comb
    begin
        wheels_on_next   = wheels_on_reg;
        wheel_drive_next = wheel_drive_reg;
        hold_count_next  = hold_count_reg;
        lockout_next     = lockout_reg;
        shots_next       = shots_reg;
        burst_next       = burst_reg;
        last_left_next   = last_left_reg;
        advances_next    = advances_reg;
        gap_next         = gap_reg;
        push_next        = push_reg;
        cyl_next         = cyl_reg;
        done_next        = 1'b0;
        feed_next        = 1'b0;
        consumed_next    = 1'b0;

        if (s1_move)
        begin
            if (!s1_active_reg)
            begin
                wheel_drive_next = 1'b0;
            end
            else
            begin
                hold_count_next = s1_right_reg ? sat_inc(hold_count_reg) : '0;
                if (!wheels_on_reg && (lockout_reg == '0))
                begin
                    if (s1_toggle_reg)
                    begin
                        wheels_on_next   = 1'b1;
                        wheel_drive_next = 1'b1;
                        consumed_next    = 1'b1;
                    end
                    if (hold_count_next != '0)
                    begin
                        wheels_on_next   = 1'b1;
                        wheel_drive_next = 1'b1;
                    end
                end
                else if (wheels_on_reg)
                begin
                    if (s1_toggle_reg)
                    begin
                        wheels_on_next   = 1'b0;
                        wheel_drive_next = 1'b0;
                        consumed_next    = 1'b1;
                    end
                    if (hold_count_next > {{(CountWidth-ShortWidth){1'b0}}, long_press_reg})
                    begin
                        wheels_on_next   = 1'b0;
                        wheel_drive_next = 1'b0;
                        lockout_next     = lockout_cfg_reg;
                    end
                end
                // The lockout counts down on the same tick that arms it.
                if (lockout_next != '0)
                begin
                    lockout_next = lockout_next - short_t'(1);
                end

                if (!wheels_on_next)
                begin
                    wheel_drive_next = 1'b0;
                end
                else
                begin
                    if (s1_left_reg)
                    begin
                        shots_next = sat_inc(shots_reg);
                        burst_next = 2'sd0;
                    end
                    if (s1_left_reg && !last_left_reg)
                    begin
                        advances_next = sat_inc(advances_reg);
                    end
                    last_left_next = s1_left_reg;
                    if (gap_next != '0)
                    begin
                        gap_next = gap_next - long_t'(1);
                    end
                    if ((gap_next == '0) && ((shots_next != '0) || (burst_next > 2'sd0)))
                    begin
                        cyl_next = 1'b1;
                        if (push_reg != '0)
                        begin
                            push_next = push_reg - long_t'(1);
                        end
                        else
                        begin
                            push_next = push_cfg_reg;
                            done_next = 1'b1;
                            cyl_next  = 1'b0;
                            if (advances_next != '0)
                            begin
                                feed_next  = 1'b1;
                                burst_next = burst_next + 2'sd1;
                                if (burst_next >= 2'sd1)
                                begin
                                    burst_next = BURST_IDLE;
                                end
                                advances_next = '0;
                            end
                            shots_next = '0;
                            gap_next   = shot_interval_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheels_on_reg   <= 1'b0;
            wheel_drive_reg <= 1'b0;
            hold_count_reg  <= '0;
            lockout_reg     <= '0;
            shots_reg       <= '0;
            burst_reg       <= BURST_IDLE;
            last_left_reg   <= 1'b0;
            advances_reg    <= '0;
            gap_reg         <= GAP_TIMER_RST;
            push_reg        <= PUSH_TIMER_RST;
            cyl_reg         <= 1'b0;
        end
        else
        begin
            wheels_on_reg   <= wheels_on_next;
            wheel_drive_reg <= wheel_drive_next;
            hold_count_reg  <= hold_count_next;
            lockout_reg     <= lockout_next;
            shots_reg       <= shots_next;
            burst_reg       <= burst_next;
            last_left_reg   <= last_left_next;
            advances_reg    <= advances_next;
            gap_reg         <= gap_next;
            push_reg        <= push_next;
            cyl_reg         <= cyl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_drive_reg    <= wheel_drive_next;
            out_cyl_reg      <= cyl_next;
            out_done_reg     <= done_next;
            out_feed_reg     <= feed_next;
            out_consumed_reg <= consumed_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign wheels_driven     = out_drive_reg;
    assign cylinder_extended = out_cyl_reg;
    assign shot_done         = out_done_reg;
    assign feed_advance      = out_feed_reg;
    assign switch_consumed   = out_consumed_reg;

`ifndef ASSERT_OFF
    // The drive is only ever on while the wheels are logically on.
    a_drive_needs_wheels: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_drive_reg |-> wheels_on_reg)
        else $error("wheel drive on while wheels are off");

    // A feed pulse only comes with a completed shot.
    a_feed_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_feed_reg) |-> out_done_reg)
        else $error("feed advance without shot done");

    // A completed shot always leaves the cylinder retracted.
    a_done_retracts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> !out_cyl_reg)
        else $error("cylinder still extended on shot done");

    // A stalled result is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_done_reg)
            && $stable(out_cyl_reg) && $stable(out_drive_reg)))
        else $error("result changed while stalled");
`endif

endmodule
